>>> rtl/prpa_pkg.sv
`default_nettype none
package prpa_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_ALLOC,
    OP_ALLOC_AT,
    OP_FIND
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_ARG,
    ST_OVERLAP,
    ST_NO_SPACE,
    ST_TABLE_FULL
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] start_addr;
    logic [63:0] size_bytes;
    logic [3:0]  region_type;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [63:0] result_addr;
    logic [63:0] result_size;
  } rsp_t;

  typedef struct packed {
    logic [51:0] start_page;
    logic [51:0] pages;
    logic [3:0]  kind;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_COPY_RD,
    S_COPY_EV,
    S_PIECE,
    S_ORIG,
    S_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic set_bad;
    logic scan_start;
    logic rd_issue;
    logic scan_eval;
    logic ptr_next;
    logic decide;
    logic exact_write;
    logic copy_start;
    logic emit_mem;
    logic emit_piece;
    logic piece_next;
    logic spec_mark;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic bad_arg;
    logic ptr_lt_cnt;
    logic scan_stop;
    logic at_spec;
    logic spec_pending;
    logic piece_last;
    logic keep_orig;
    logic dec_copy;
    logic dec_exact;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/prpa_ctrl.sv
`default_nettype none
module prpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prpa_pkg::sts_t sts,
  output prpa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import prpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_arg) begin
          cmd.set_bad = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.ptr_lt_cnt) begin
          cmd.rd_issue = 1'b1;
          state_next = S_SCAN_EV;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        if (sts.scan_stop) begin
          state_next = S_DECIDE;
        end else begin
          cmd.ptr_next = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.dec_exact) begin
          cmd.exact_write = 1'b1;
          state_next = S_DONE;
        end else if (sts.dec_copy) begin
          cmd.copy_start = 1'b1;
          state_next = S_COPY_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COPY_RD: begin
        if (sts.ptr_lt_cnt) begin
          cmd.rd_issue = 1'b1;
          state_next = S_COPY_EV;
        end else if (sts.spec_pending) begin
          state_next = S_PIECE;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_COPY_EV: begin
        if (sts.at_spec) begin
          state_next = S_PIECE;
        end else begin
          cmd.emit_mem = 1'b1;
          cmd.ptr_next = 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_PIECE: begin
        cmd.emit_piece = 1'b1;
        cmd.piece_next = 1'b1;
        if (sts.piece_last) begin
          cmd.spec_mark = 1'b1;
          if (sts.ptr_lt_cnt && sts.keep_orig) begin
            state_next = S_ORIG;
          end else if (sts.ptr_lt_cnt) begin
            cmd.ptr_next = 1'b1;
            state_next = S_COPY_RD;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_ORIG: begin
        cmd.emit_mem = 1'b1;
        cmd.ptr_next = 1'b1;
        state_next = S_COPY_RD;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/prpa_dp.sv
`default_nettype none
module prpa_dp (
  input  logic           clk,
  input  logic           rst,
  input  prpa_pkg::cmd_t cmd,
  output prpa_pkg::sts_t sts,
  input  prpa_pkg::req_t request,
  input  logic [3:0]     free_type,
  input  logic [52:0]    ceiling,
  output prpa_pkg::rsp_t result
);
  import prpa_pkg::*;

  // two table banks: a rebuild streams from the current bank into the other
  entry_t bank0 [MAX_REGIONS];
  entry_t bank1 [MAX_REGIONS];
  entry_t rd0, rd1, rdata;
  logic   cur;

  req_t              rq;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  sidx;
  logic [CNT_W-1:0]  wr;
  logic [52:0]       lp;
  logic [20:0]       need;
  logic              hit;
  logic              pos_found;
  entry_t            cap;
  logic [52:0]       cap_lim;

  entry_t            piece [3];
  logic [2:0]        pv;
  logic              keep_orig;
  logic [1:0]        pc;
  logic              spec_done;

  entry_t            acc;
  logic              acc_valid;

  // request decode
  logic [51:0] sp;
  logic [64:0] sum65;
  logic        rbad;
  logic        bad;
  logic [52:0] lp_calc;
  logic [20:0] need_calc;

  assign sp = rq.start_addr[63:12];
  assign sum65 = {1'b0, rq.start_addr} + {1'b0, rq.size_bytes};
  assign rbad = (rq.start_addr[11:0] != 12'h0) || (rq.size_bytes == 64'h0) ||
                (rq.size_bytes[11:0] != 12'h0) || sum65[64];
  assign lp_calc = {1'b0, sp} + {1'b0, rq.size_bytes[63:12]};
  assign need_calc = {1'b0, rq.size_bytes[31:12]} + 21'(|rq.size_bytes[11:0]);

  always_comb begin
    case (rq.kind)
      OP_CREATE:   bad = rbad;
      OP_ALLOC:    bad = (rq.size_bytes == 64'h0) || (rq.size_bytes[63:32] != 32'h0) ||
                         (rq.region_type == free_type);
      OP_ALLOC_AT: bad = rbad || (rq.region_type == free_type);
      default:     bad = 1'b0;
    endcase
  end

  // scan evaluation on the entry just read
  logic [52:0] e_lim;
  logic        ov, fit, contain, is_free, match;

  assign rdata   = cur ? rd1 : rd0;
  assign e_lim   = {1'b0, rdata.start_page} + {1'b0, rdata.pages};
  assign ov      = ({1'b0, sp} < e_lim) && (lp > {1'b0, rdata.start_page});
  assign is_free = (rdata.kind == free_type);
  assign fit     = is_free && (rdata.pages >= 52'(need)) && (e_lim < ceiling);
  assign contain = (sp >= rdata.start_page) && (lp <= e_lim);

  always_comb begin
    case (rq.kind)
      OP_CREATE:   match = ov;
      OP_ALLOC:    match = fit;
      OP_ALLOC_AT: match = contain;
      default:     match = is_free;
    endcase
  end

  // decision after the scan
  logic        cnt_full;
  logic [1:0]  extra;
  logic        over;
  logic [52:0] ns;
  logic [51:0] d_lo;
  logic [52:0] d_hi;
  logic        dec_exact, dec_copy, keep_n;
  rsp_t        res_n;
  entry_t      pn [3];
  logic [2:0]  pv_n;

  assign cnt_full = (count >= MAX_CNT);
  assign extra = {1'b0, cap.start_page < sp} + {1'b0, cap_lim > lp};
  assign over = ({1'b0, count} + (CNT_W+1)'(extra)) > (CNT_W+1)'(MAX_REGIONS);
  assign ns = cap_lim - 53'(need);
  assign d_lo = sp - cap.start_page;
  assign d_hi = cap_lim - lp;

  always_comb begin
    dec_exact = 1'b0;
    dec_copy = 1'b0;
    keep_n = 1'b0;
    res_n = '0;
    res_n.status = ST_OK;
    pv_n = 3'b000;
    pn[0] = '0;
    pn[1] = '0;
    pn[2] = '0;
    case (rq.kind)
      OP_CREATE: begin
        if (hit) begin
          res_n.status = ST_OVERLAP;
        end else if (cnt_full) begin
          res_n.status = ST_TABLE_FULL;
        end else begin
          dec_copy = 1'b1;
          keep_n = 1'b1;
          pv_n = 3'b001;
          pn[0] = '{start_page: sp, pages: rq.size_bytes[63:12], kind: rq.region_type};
        end
      end
      OP_ALLOC: begin
        if (!hit) begin
          res_n.status = ST_NO_SPACE;
        end else if (cap.pages == 52'(need)) begin
          dec_exact = 1'b1;
          res_n.result_addr = {cap.start_page, 12'h0};
        end else if (cnt_full) begin
          res_n.status = ST_TABLE_FULL;
        end else begin
          dec_copy = 1'b1;
          pv_n = 3'b011;
          pn[0] = '{start_page: cap.start_page, pages: cap.pages - 52'(need),
                    kind: cap.kind};
          pn[1] = '{start_page: ns[51:0], pages: 52'(need), kind: rq.region_type};
          res_n.result_addr = {ns[51:0], 12'h0};
        end
      end
      OP_ALLOC_AT: begin
        if (!hit || (cap.kind != free_type)) begin
          res_n.status = ST_OK;
        end else if (over) begin
          res_n.status = ST_TABLE_FULL;
        end else begin
          dec_copy = 1'b1;
          res_n.found = 1'b1;
          res_n.result_addr = rq.start_addr;
          pv_n = {cap_lim > lp, 1'b1, cap.start_page < sp};
          pn[0] = '{start_page: cap.start_page, pages: d_lo, kind: cap.kind};
          pn[1] = '{start_page: sp, pages: rq.size_bytes[63:12], kind: rq.region_type};
          pn[2] = '{start_page: lp[51:0], pages: d_hi[51:0], kind: cap.kind};
        end
      end
      default: begin
        if (hit) begin
          res_n.found = 1'b1;
          res_n.result_addr = {cap.start_page, 12'h0};
          res_n.result_size = {cap.pages, 12'h0};
        end
      end
    endcase
  end

  // merge accumulator input
  entry_t      pin;
  logic        pin_valid;
  logic [52:0] acc_lim;
  logic        join_acc;

  always_comb begin
    case (pc)
      2'd0:    pin = piece[0];
      2'd1:    pin = piece[1];
      default: pin = piece[2];
    endcase
    pin_valid = pv[pc];
    if (cmd.emit_mem) begin
      pin = rdata;
      pin_valid = 1'b1;
    end
  end

  assign acc_lim = {1'b0, acc.start_page} + {1'b0, acc.pages};
  assign join_acc = acc_valid && (acc_lim == {1'b0, pin.start_page}) && (acc.kind == pin.kind);

  // memory write port
  logic             we, wbank;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  always_comb begin
    we = 1'b0;
    wbank = ~cur;
    waddr = wr[IDX_W-1:0];
    wdata = acc;
    if (cmd.exact_write) begin
      we = 1'b1;
      wbank = cur;
      waddr = sidx[IDX_W-1:0];
      wdata = '{start_page: cap.start_page, pages: cap.pages, kind: rq.region_type};
    end else if (((cmd.emit_mem || (cmd.emit_piece && pin_valid)) && acc_valid && !join_acc) ||
                 (cmd.flush && acc_valid)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      bank0[waddr] <= wdata;
    end
    if (we && wbank) begin
      bank1[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rd0 <= bank0[ptr[IDX_W-1:0]];
      rd1 <= bank1[ptr[IDX_W-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= 1'b0;
      count <= '0;
      acc_valid <= 1'b0;
      spec_done <= 1'b0;
    end else begin
      if (cmd.copy_start) begin
        acc_valid <= 1'b0;
        spec_done <= 1'b0;
      end
      if (cmd.spec_mark) begin
        spec_done <= 1'b1;
      end
      if ((cmd.emit_mem || (cmd.emit_piece && pin_valid)) && !join_acc) begin
        acc_valid <= 1'b1;
      end
      if (cmd.flush) begin
        cur <= ~cur;
        count <= wr + CNT_W'(acc_valid);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq <= request;
    end
    if (cmd.set_bad) begin
      result <= '{status: ST_BAD_ARG, found: 1'b0, result_addr: 64'h0, result_size: 64'h0};
    end
    if (cmd.scan_start) begin
      ptr <= '0;
      hit <= 1'b0;
      pos_found <= 1'b0;
      sidx <= count;
      lp <= lp_calc;
      need <= need_calc;
    end
    if (cmd.scan_eval) begin
      if (match) begin
        hit <= 1'b1;
        cap <= rdata;
        cap_lim <= e_lim;
        if (rq.kind != OP_CREATE) begin
          sidx <= ptr;
        end
      end
      if ((rq.kind == OP_CREATE) && !pos_found && (rdata.start_page > sp)) begin
        pos_found <= 1'b1;
        sidx <= ptr;
      end
    end
    if (cmd.ptr_next) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.decide) begin
      result <= res_n;
      piece[0] <= pn[0];
      piece[1] <= pn[1];
      piece[2] <= pn[2];
      pv <= pv_n;
      keep_orig <= keep_n;
    end
    if (cmd.copy_start) begin
      ptr <= '0;
      wr <= '0;
      pc <= 2'd0;
    end
    if (cmd.piece_next) begin
      pc <= pc + 2'd1;
    end
    if (cmd.emit_mem || (cmd.emit_piece && pin_valid)) begin
      if (join_acc) begin
        acc.pages <= acc.pages + pin.pages;
      end else begin
        acc <= pin;
        if (acc_valid) begin
          wr <= wr + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.bad_arg = bad;
    sts.ptr_lt_cnt = (ptr < count);
    sts.scan_stop = match && (rq.kind != OP_ALLOC);
    sts.at_spec = (ptr == sidx) && !spec_done;
    sts.spec_pending = !spec_done;
    sts.piece_last = (pc == 2'd2);
    sts.keep_orig = keep_orig;
    sts.dec_copy = dec_copy;
    sts.dec_exact = dec_exact;
  end

endmodule
`default_nettype wire

>>> rtl/physical_region_allocator.sv
`default_nettype none
// Physical region table: create, allocate-from-top, allocate-at and find-free requests.
// Request channel: drive request and pulse start while busy is low; the request is taken
// at that edge and busy stays high until the result has been shown.
// Result channel: done is high for exactly one cycle with result valid; there is no
// back-pressure, so the receiver must take it in that cycle.
// A bad argument goes from the check state straight to done. Otherwise a scan reads the
// table entry by entry (a registered memory read, then the compare); then, for requests
// that insert, a rebuild streams every entry into the other bank, adding up to three new
// pieces at the scan position (and, for create, keeping the entry it lands in front of) and
// merging touching regions of the same type on the fly. One request is handled at a time.
// Config: APB registers, free_type at 0x0 and alloc_ceiling_page at 0x8, to be written only
// while busy is low; the block does not enforce this. pready is tied high.
// Reset empties the table (count zero) and loads the register defaults; no clearing pass.
module physical_region_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  prpa_pkg::req_t      request,
  output logic                busy,
  output logic                done,
  output prpa_pkg::rsp_t      result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import prpa_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  free_type;
  logic [52:0] ceiling;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_type <= 4'h0;
      ceiling <= 53'd1048576;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        ceiling <= pwdata[52:0];
      end else begin
        free_type <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[3] ? {11'h0, ceiling} : {60'h0, free_type};

  prpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  prpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .request   (request),
    .free_type (free_type),
    .ceiling   (ceiling),
    .result    (result)
  );

endmodule
`default_nettype wire
